// File: hw/rtl/lz_token_stream_decoder_macros.svh
// assertion helpers for the token stream decoder
// every check is clocked on clk and held off while rst is high
`ifndef LZ_TOKEN_STREAM_DECODER_MACROS_SVH
`define LZ_TOKEN_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LZD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzd check failed");
// next-cycle implication
`define LZD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzd check failed");
`else
`define LZD_ASSERT_NOW(label, ante, cons)
`define LZD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/lzd_pkg.sv
package lzd_pkg;

  // field widths
  localparam int BYTE_W  = 8;
  localparam int SCALE_W = 7;
  localparam int ACCUM_W = 16;
  localparam int DIST_W  = ACCUM_W + SCALE_W;
  localparam int LEN_W   = 6;
  localparam int CODE_W  = 5;

  // reset value of the scale register
  localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd32;

  // match length per length code
  localparam logic [LEN_W-1:0] LEN_TABLE [32] = '{
    6'd0,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,
    6'd9,  6'd10, 6'd11, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20,
    6'd22, 6'd24, 6'd26, 6'd28, 6'd30, 6'd32, 6'd34, 6'd36,
    6'd38, 6'd40, 6'd43, 6'd46, 6'd49, 6'd52, 6'd55, 6'd60
  };

  // one result beat headed for the output register
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              bad;
  } beat_t;

endpackage

// File: hw/rtl/lz_token_stream_decoder.sv
// LZ77-style token stream decoder. One compressed byte is taken per beat on
// the input channel; decoded bytes leave one per beat through an output
// register. A header or literal byte is taken and emitted; token and distance
// bytes are taken and emit nothing. When a match runs, the decoder first forms
// the scaled distance (ST_MUL) and checks it (ST_CHK), then copies through the
// history RAM one byte at a time (a read in ST_RD, then the write-back of that
// byte in ST_WR, which waits while the output register is held), and a rejected
// distance gives a single flagged beat. The input stalls for the whole match.
// History is only read where the current stream has written it, so the RAM
// needs no clearing after reset.
`include "lz_token_stream_decoder_macros.svh"

module lz_token_stream_decoder import lzd_pkg::*; #(
  parameter int HISTORY_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SCALE_W-1:0] distance_scale,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_byte,
  input  logic               stream_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               run_last,
  output logic               status
);

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int AW1 = AW + 1;
  localparam int PW  = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W   = AW1'(HISTORY_DEPTH);
  localparam logic [PW-1:0] DEPTH_P   = PW'(HISTORY_DEPTH);

  // parse phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_TOKEN  = 3'd1;
  localparam logic [2:0] PH_DLO    = 3'd2;
  localparam logic [2:0] PH_DHI    = 3'd3;
  localparam logic [2:0] PH_LIT    = 3'd4;

  // match engine states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;
  localparam logic [2:0] ST_BAD  = 3'd5;

  logic [2:0]         state;
  logic [2:0]         phase;
  logic [SCALE_W-1:0] scale;
  logic [SCALE_W-1:0] hdr_rem;
  logic [1:0]         lit_rem;
  logic [CODE_W-1:0]  len_code;
  logic               wide;
  logic [ACCUM_W-1:0] accum;
  logic [AW-1:0]      wp;
  logic [PW-1:0]      produced;
  logic [DIST_W-1:0]  match_dist;
  logic [AW-1:0]      src;
  logic [LEN_W-1:0]   cnt;

  logic [2:0]         phase_next;
  logic [SCALE_W-1:0] hdr_next;
  logic [1:0]         lit_next;
  logic [CODE_W-1:0]  code_next;
  logic               wide_next;
  logic [ACCUM_W-1:0] accum_next;
  logic [AW-1:0]      wp_base;
  logic [AW-1:0]      wp_next;
  logic [PW-1:0]      prod_base;
  logic [PW-1:0]      produced_next;

  logic [2:0]         ph;
  logic [SCALE_W-1:0] hdr_eff;
  logic [1:0]         lit_eff;
  logic [CODE_W-1:0]  code_eff;
  logic               wide_eff;
  logic [ACCUM_W-1:0] accum_eff;
  logic               byte_take;
  logic               take_last;
  logic               go_match;

  logic               accept;
  logic               can_load;
  logic               copy_wr;
  logic               hist_we;
  logic [BYTE_W-1:0]  hist_wdata;
  logic [BYTE_W-1:0]  hist_rdata;
  logic               emit;
  beat_t              beat;
  logic               dist_ok;
  logic [AW:0]        back;
  logic [AW:0]        back_wrap;
  logic [AW-1:0]      src_start;

  function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
    addr_inc = (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  // handshakes
  assign accept    = in_valid && !in_stall;
  assign in_stall  = !((state == ST_IDLE) && can_load);
  assign cfg_ready = (state == ST_IDLE);

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale <= distance_scale;
    end
  end

  // byte parser: stream start restarts the header, then one phase per byte
  always_comb begin
    ph        = stream_start ? PH_HEADER : phase;
    hdr_eff   = stream_start ? scale : hdr_rem;
    lit_eff   = stream_start ? 2'd0 : lit_rem;
    code_eff  = stream_start ? '0 : len_code;
    wide_eff  = stream_start ? 1'b0 : wide;
    accum_eff = stream_start ? '0 : accum;
    if ((ph == PH_HEADER) && (hdr_eff == '0)) begin
      ph = PH_TOKEN;
    end
    phase_next = ph;
    hdr_next   = hdr_eff;
    lit_next   = lit_eff;
    code_next  = code_eff;
    wide_next  = wide_eff;
    accum_next = accum_eff;
    byte_take  = 1'b0;
    take_last  = 1'b0;
    go_match   = 1'b0;
    case (ph)
      PH_HEADER: begin
        byte_take = 1'b1;
        take_last = 1'b1;
        hdr_next  = hdr_eff - 1'b1;
        if (hdr_eff == SCALE_W'(1)) begin
          phase_next = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        lit_next   = in_byte[7:6];
        wide_next  = in_byte[5];
        code_next  = in_byte[4:0];
        accum_next = '0;
        if (LEN_TABLE[in_byte[4:0]] != '0) begin
          phase_next = PH_DLO;
        end else if (in_byte[7:6] != 2'd0) begin
          phase_next = PH_LIT;
        end else begin
          phase_next = PH_TOKEN;
        end
      end
      PH_DLO: begin
        accum_next = {8'h00, in_byte};
        if (wide_eff) begin
          phase_next = PH_DHI;
        end else if (lit_eff != 2'd0) begin
          phase_next = PH_LIT;
        end else begin
          go_match   = 1'b1;
          phase_next = PH_TOKEN;
        end
      end
      PH_DHI: begin
        accum_next = {in_byte, accum_eff[7:0]};
        if (lit_eff != 2'd0) begin
          phase_next = PH_LIT;
        end else begin
          go_match   = 1'b1;
          phase_next = PH_TOKEN;
        end
      end
      default: begin
        // literal byte
        byte_take = 1'b1;
        lit_next  = lit_eff - 1'b1;
        take_last = 1'b1;
        if (lit_eff == 2'd1) begin
          phase_next = PH_TOKEN;
          if (LEN_TABLE[code_eff] != '0) begin
            go_match  = 1'b1;
            take_last = 1'b0;
          end
        end
      end
    endcase
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      hdr_rem  <= '0;
      lit_rem  <= '0;
      len_code <= '0;
      wide     <= 1'b0;
      accum    <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      hdr_rem  <= hdr_next;
      lit_rem  <= lit_next;
      len_code <= code_next;
      wide     <= wide_next;
      accum    <= accum_next;
    end
  end

  // history write side: parser bytes or copy write-back
  assign copy_wr    = (state == ST_WR) && can_load;
  assign hist_we    = (accept && byte_take) || copy_wr;
  assign hist_wdata = (state == ST_WR) ? hist_rdata : in_byte;

  // write pointer and fill count, cleared by stream start
  always_comb begin
    wp_base       = (accept && stream_start) ? '0 : wp;
    prod_base     = (accept && stream_start) ? '0 : produced;
    wp_next       = wp_base;
    produced_next = prod_base;
    if (hist_we) begin
      wp_next = addr_inc(wp_base);
      if (prod_base != DEPTH_P) begin
        produced_next = prod_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      produced <= '0;
    end else begin
      wp       <= wp_next;
      produced <= produced_next;
    end
  end

  // distance check and copy source
  assign dist_ok   = (match_dist != '0) && (32'(match_dist) <= 32'(produced));
  assign back      = {1'b0, wp} - match_dist[AW:0];
  assign back_wrap = back + DEPTH_W;
  assign src_start = back[AW] ? back_wrap[AW-1:0] : back[AW-1:0];

  // match engine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && go_match) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          state <= dist_ok ? ST_RD : ST_BAD;
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          if (can_load) begin
            state <= (cnt == LEN_W'(1)) ? ST_IDLE : ST_RD;
          end
        end
        ST_BAD: begin
          if (can_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // match datapath
  always_ff @(posedge clk) begin
    if (accept && go_match) begin
      cnt <= LEN_TABLE[code_next];
    end else if (copy_wr) begin
      cnt <= cnt - 1'b1;
    end
    if (state == ST_MUL) begin
      match_dist <= DIST_W'(accum) * DIST_W'(scale);
    end
    if (state == ST_CHK) begin
      src <= src_start;
    end else if (copy_wr) begin
      src <= addr_inc(src);
    end
  end

  lzd_hist_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (wp_base),
    .wdata (hist_wdata),
    .re    (state == ST_RD),
    .raddr (src),
    .rdata (hist_rdata)
  );

  // result beat
  always_comb begin
    emit      = hist_we || ((state == ST_BAD) && can_load);
    beat.data = hist_wdata;
    beat.last = take_last;
    beat.bad  = 1'b0;
    case (state)
      ST_WR: begin
        beat.last = (cnt == LEN_W'(1));
      end
      ST_BAD: begin
        beat.data = '0;
        beat.last = 1'b1;
        beat.bad  = 1'b1;
      end
      default: begin
        beat.last = take_last;
      end
    endcase
  end

  lzd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .beat      (beat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .status    (status),
    .can_load  (can_load)
  );

  // checks
  `LZD_ASSERT_NOW(a_accept_idle, accept, state == ST_IDLE)
  `LZD_ASSERT_NOW(a_copy_count, (state == ST_RD) || (state == ST_WR), cnt != '0)
  `LZD_ASSERT_NOW(a_fill_bound, 1'b1, produced <= DEPTH_P)
  `LZD_ASSERT_NEXT(a_match_start, accept && go_match, state == ST_MUL)

endmodule

// File: hw/rtl/lzd_hist_ram.sv
module lzd_hist_ram import lzd_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/lzd_out_stage.sv
module lzd_out_stage import lzd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  beat_t             beat,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [BYTE_W-1:0] out_byte,
  output logic              run_last,
  output logic              status,
  output logic              can_load
);

  // slot frees up when empty or being taken this cycle
  assign can_load = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_byte <= beat.data;
      run_last <= beat.last;
      status   <= beat.bad;
    end
  end

endmodule
